FILE: hdl/priority_led_multiplexer_defines.svh
// Assertion macros for the priority LED multiplexer.
// No dependencies; included by the top level only.
`ifndef PRIORITY_LED_MULTIPLEXER_DEFINES_SVH
`define PRIORITY_LED_MULTIPLEXER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define PLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define PLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/plm_pkg.sv
// Shared types and constants of the priority LED multiplexer.
// No dependencies; used by every other file of the block but the assertion macro header.
package plm_pkg;

   localparam int unsigned COLOR_W = 24;
   localparam int unsigned TIME_W  = 16;

   localparam logic [1:0] ATTENTION_SLOT = 2'd2;

   localparam logic [1:0] MODE_SOLID    = 2'd0;
   localparam logic [1:0] MODE_TIMED    = 2'd1;
   localparam logic [1:0] MODE_HARDWARE = 2'd2;
   localparam logic [1:0] MODE_INVALID  = 2'd3;

   localparam logic [COLOR_W-1:0] COLOR_MASK = 24'hff_ffff;

   // What the result register is loaded with.
   typedef enum logic [2:0] {
      EMIT_REJECT = 3'd0,
      EMIT_NOUPD  = 3'd1,
      EMIT_REQ    = 3'd2,
      EMIT_ENTRY  = 3'd3,
      EMIT_OFF    = 3'd4
   } emit_kind_type;

   typedef struct packed {
      logic          load;       // capture an accepted request
      logic          store;      // write the request into its slot entry
      logic          scan_init;  // start the fallback scan at the request slot
      logic          scan_dec;   // step the scan one slot down
      logic          emit;       // load the result register
      emit_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic bad;        // invalid slot or flash mode
      logic show_new;   // request is lit and wins the LED
      logic fall_back;  // request darkens the shown slot
      logic scan_done;  // no slot left below the scan pointer
      logic scan_hit;   // slot below the scan pointer is lit
      logic out_free;   // result register can take a result this cycle
   } dp_status_type;

endpackage

FILE: hdl/plm_if.sv
// Valid/ready channels of the priority LED multiplexer: request and response.
// Depends on plm_pkg for field widths.
interface plm_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       slot;
   logic [plm_pkg::COLOR_W-1:0]      rgb_color;
   logic [1:0]                       flash_mode;
   logic [plm_pkg::TIME_W-1:0]       on_ms;
   logic [plm_pkg::TIME_W-1:0]       off_ms;

   modport source (output valid, slot, rgb_color, flash_mode, on_ms, off_ms, input ready);
   modport sink   (input valid, slot, rgb_color, flash_mode, on_ms, off_ms, output ready);
endinterface

interface plm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             drive_update;
   logic [plm_pkg::COLOR_W-1:0]      drive_color;
   logic [plm_pkg::TIME_W-1:0]       drive_on_ms;
   logic [plm_pkg::TIME_W-1:0]       drive_off_ms;
   logic                             status;

   modport source (output valid, drive_update, drive_color, drive_on_ms, drive_off_ms,
                   status, input ready);
   modport sink   (input valid, drive_update, drive_color, drive_on_ms, drive_off_ms,
                   status, output ready);
endinterface

FILE: hdl/plm_ctrl.sv
// Controller of the priority LED multiplexer: request, evaluate, fallback scan.
// Depends on plm_pkg for the command and status structs.
module plm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  plm_pkg::dp_status_type st,
   output plm_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.kind      = plm_pkg::EMIT_NOUPD;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (st.out_free) begin
               if (st.bad) begin
                  cmd.emit = 1'b1;
                  cmd.kind = plm_pkg::EMIT_REJECT;
                  state_in = ST_IDLE;
               end else if (st.show_new) begin
                  cmd.store = 1'b1;
                  cmd.emit  = 1'b1;
                  cmd.kind  = plm_pkg::EMIT_REQ;
                  state_in  = ST_IDLE;
               end else if (st.fall_back) begin
                  cmd.store     = 1'b1;
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  cmd.store = 1'b1;
                  cmd.emit  = 1'b1;
                  cmd.kind  = plm_pkg::EMIT_NOUPD;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (st.out_free) begin
               if (st.scan_done) begin
                  cmd.emit = 1'b1;
                  cmd.kind = plm_pkg::EMIT_OFF;
                  state_in = ST_IDLE;
               end else if (st.scan_hit) begin
                  cmd.emit = 1'b1;
                  cmd.kind = plm_pkg::EMIT_ENTRY;
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_dec = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/plm_dp.sv
// Datapath of the priority LED multiplexer: request register, slot entries,
// shown-slot tracking, scan pointer and result register. Depends on plm_pkg.
module plm_dp #(
   parameter int NUM_SLOTS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_slot,
   input  logic [plm_pkg::COLOR_W-1:0]   req_rgb_color,
   input  logic [1:0]                    req_flash_mode,
   input  logic [plm_pkg::TIME_W-1:0]    req_on_ms,
   input  logic [plm_pkg::TIME_W-1:0]    req_off_ms,
   input  plm_pkg::dp_cmd_type           cmd,
   output plm_pkg::dp_status_type        st,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_drive_update,
   output logic [plm_pkg::COLOR_W-1:0]   rsp_drive_color,
   output logic [plm_pkg::TIME_W-1:0]    rsp_drive_on_ms,
   output logic [plm_pkg::TIME_W-1:0]    rsp_drive_off_ms,
   output logic                          rsp_status
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   // Normalized request
   logic                          cur_bad_ff, cur_bad_in;
   logic [SLOT_W-1:0]             cur_idx_ff;
   logic [plm_pkg::COLOR_W-1:0]   cur_color_ff, cur_color_in;
   logic [plm_pkg::TIME_W-1:0]    cur_on_ff, cur_on_in;
   logic [plm_pkg::TIME_W-1:0]    cur_off_ff, cur_off_in;

   // Slot entries
   logic [plm_pkg::COLOR_W-1:0]   color_ff [NUM_SLOTS];
   logic [plm_pkg::TIME_W-1:0]    on_ff    [NUM_SLOTS];
   logic [plm_pkg::TIME_W-1:0]    off_ff   [NUM_SLOTS];

   logic                          shown_valid_ff;
   logic [SLOT_W-1:0]             shown_idx_ff;
   logic [SLOT_W-1:0]             ptr_ff;
   logic [SLOT_W-1:0]             scan_idx;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          upd_ff, upd_in;
   logic [plm_pkg::COLOR_W-1:0]   col_ff, col_in;
   logic [plm_pkg::TIME_W-1:0]    don_ff, don_in;
   logic [plm_pkg::TIME_W-1:0]    doff_ff, doff_in;
   logic                          sts_ff, sts_in;

   logic attention;
   logic solid;

   // Normalize the incoming request
   always_comb begin
      attention  = (req_slot == plm_pkg::ATTENTION_SLOT);
      cur_bad_in = (32'(req_slot) >= NUM_SLOTS) ||
                   (req_flash_mode == plm_pkg::MODE_INVALID);
      solid      = (req_flash_mode == plm_pkg::MODE_SOLID) ||
                   (attention && req_flash_mode == plm_pkg::MODE_HARDWARE &&
                    req_on_ms != '0 && req_off_ms == '0);
      cur_color_in = (attention && req_flash_mode == plm_pkg::MODE_SOLID) ?
                     '0 : (req_rgb_color & plm_pkg::COLOR_MASK);
      cur_on_in    = solid ? '0 : req_on_ms;
      cur_off_in   = solid ? '0 : req_off_ms;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_bad_ff   <= cur_bad_in;
         cur_idx_ff   <= SLOT_W'(req_slot);
         cur_color_ff <= cur_color_in;
         cur_on_ff    <= cur_on_in;
         cur_off_ff   <= cur_off_in;
      end
   end

   assign scan_idx = ptr_ff - SLOT_W'(1);

   always_comb begin
      st.bad       = cur_bad_ff;
      st.show_new  = (cur_color_ff != '0) &&
                     (!shown_valid_ff || cur_idx_ff >= shown_idx_ff);
      st.fall_back = (cur_color_ff == '0) && shown_valid_ff &&
                     (cur_idx_ff == shown_idx_ff);
      st.scan_done = (ptr_ff == '0);
      st.scan_hit  = (color_ff[scan_idx] != '0);
      st.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            color_ff[i] <= '0;
            on_ff[i]    <= '0;
            off_ff[i]   <= '0;
         end
      end else if (cmd.store) begin
         color_ff[cur_idx_ff] <= cur_color_ff;
         on_ff[cur_idx_ff]    <= cur_on_ff;
         off_ff[cur_idx_ff]   <= cur_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         ptr_ff <= cur_idx_ff;
      end else if (cmd.scan_dec) begin
         ptr_ff <= scan_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_valid_ff <= 1'b0;
         shown_idx_ff   <= '0;
      end else if (cmd.emit) begin
         case (cmd.kind)
            plm_pkg::EMIT_REQ: begin
               shown_valid_ff <= 1'b1;
               shown_idx_ff   <= cur_idx_ff;
            end
            plm_pkg::EMIT_ENTRY: shown_idx_ff   <= scan_idx;
            plm_pkg::EMIT_OFF:   shown_valid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // Result register
   always_comb begin
      upd_in  = 1'b0;
      col_in  = '0;
      don_in  = '0;
      doff_in = '0;
      sts_in  = 1'b0;
      case (cmd.kind)
         plm_pkg::EMIT_REJECT: sts_in = 1'b1;
         plm_pkg::EMIT_REQ: begin
            upd_in  = 1'b1;
            col_in  = cur_color_ff;
            don_in  = cur_on_ff;
            doff_in = cur_off_ff;
         end
         plm_pkg::EMIT_ENTRY: begin
            upd_in  = 1'b1;
            col_in  = color_ff[scan_idx];
            don_in  = on_ff[scan_idx];
            doff_in = off_ff[scan_idx];
         end
         plm_pkg::EMIT_OFF: upd_in = 1'b1;
         default: ;
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         upd_ff  <= upd_in;
         col_ff  <= col_in;
         don_ff  <= don_in;
         doff_ff <= doff_in;
         sts_ff  <= sts_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_update = upd_ff;
   assign rsp_drive_color  = col_ff;
   assign rsp_drive_on_ms  = don_ff;
   assign rsp_drive_off_ms = doff_ff;
   assign rsp_status       = sts_ff;

endmodule

FILE: hdl/priority_led_multiplexer.sv
// Top level of the priority LED multiplexer: controller plus datapath.
// Depends on plm_pkg, plm_if, plm_ctrl, plm_dp and the assertion macro header.
//
//   channel | dir | payload                                              | transfer
//   --------+-----+------------------------------------------------------+-----------------
//   req     | in  | slot, rgb_color, flash_mode, on_ms, off_ms           | valid && ready
//   rsp     | out | drive_update, drive_color, drive_on_ms, drive_off_ms,| valid && ready
//           |     | status                                               |
//
// One request at a time. After its transfer a request passes through the
// evaluate state before the controller is back to accept the next one. A request
// that darkens the shown slot then runs the one-slot-per-cycle fallback scan while
// the response is free, down to the highest lit lower slot, or to off if none is lit.
// Reset clears every slot entry and the shown slot in the same cycle.
// The result sits in an output register; a new request is taken while it
// waits, but the evaluate step and every scan step stall until the response
// is free.
`include "priority_led_multiplexer_defines.svh"

module priority_led_multiplexer #(
   parameter int NUM_SLOTS = 3
) (
   input  logic       clock,
   input  logic       reset,
   plm_req_if.sink    req,
   plm_rsp_if.source  rsp
);

   plm_pkg::dp_cmd_type    cmd;
   plm_pkg::dp_status_type st;
   logic                   ready;

   // Sequence each request: capture, evaluate, optional fallback scan
   plm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .st        (st),
      .cmd       (cmd)
   );

   assign req.ready = ready;

   // Hold the slot entries, shown slot and result register
   plm_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_slot         (req.slot),
      .req_rgb_color    (req.rgb_color),
      .req_flash_mode   (req.flash_mode),
      .req_on_ms        (req.on_ms),
      .req_off_ms       (req.off_ms),
      .cmd              (cmd),
      .st               (st),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_drive_update (rsp.drive_update),
      .rsp_drive_color  (rsp.drive_color),
      .rsp_drive_on_ms  (rsp.drive_on_ms),
      .rsp_drive_off_ms (rsp.drive_off_ms),
      .rsp_status       (rsp.status)
   );

   // A transferred request blocks the next one until its result is produced
   `PLM_ASSERT_NEXT(a_one_in_flight, clock, reset, req.valid && ready, !ready, "second request taken while one is in flight")

   // Never overwrite a result that has not been transferred
   `PLM_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.emit, !rsp.valid || rsp.ready, "pending result overwritten")

   // A rejected request shows up as an error result with no LED rewrite
   `PLM_ASSERT_NEXT(a_reject_result, clock, reset, cmd.emit && cmd.kind == plm_pkg::EMIT_REJECT, rsp.valid && rsp.status && !rsp.drive_update, "reject result malformed")

endmodule

FILE: test/tb.sv
// Self-checking testbench for the priority LED multiplexer.
// Depends on plm_pkg, plm_if and the priority_led_multiplexer RTL.
`timescale 1ns / 100ps

module tb;

   localparam int NUM_SLOTS = 3;

   localparam int unsigned COLOR_W = plm_pkg::COLOR_W;
   localparam int unsigned TIME_W  = plm_pkg::TIME_W;

   // Slot codes not named in the package.
   localparam logic [1:0] SLOT_BATTERY = 2'd0;
   localparam logic [1:0] SLOT_NOTIFY  = 2'd1;
   localparam logic [1:0] SLOT_INVALID = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam int RANDOM_ITEMS = 1800;
   localparam int PHASES       = 4;
   // Settling time after the last drive: room for a worst request, one that scans every slot.
   localparam int SETTLE       = NUM_SLOTS + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [1:0]         slot;
      logic [COLOR_W-1:0] color;
      logic [1:0]         mode;
      logic [TIME_W-1:0]  on_ms;
      logic [TIME_W-1:0]  off_ms;
   } led_req_type;

   typedef struct packed {
      logic               update;
      logic [COLOR_W-1:0] color;
      logic [TIME_W-1:0]  on_ms;
      logic [TIME_W-1:0]  off_ms;
      logic               status;
   } led_drive_type;

   // A typed row carries its own expected drive; other rows use the predictor.
   typedef struct packed {
      led_req_type   req;
      logic          typed;
      led_drive_type want;
   } script_row_type;

   localparam led_drive_type DRIVE_REJECT = '{1'b0, 24'h0, 16'h0, 16'h0, STATUS_BAD};
   localparam led_drive_type DRIVE_NONE   = '{1'b0, 24'h0, 16'h0, 16'h0, STATUS_OK};

   localparam int SCRIPT_LEN = 22;

   logic clock;
   logic reset;

   plm_req_if req_ch ();
   plm_rsp_if rsp_ch ();

   priority_led_multiplexer #(.NUM_SLOTS(NUM_SLOTS)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Directed script: extremes, every mode, rejects and the fallback chain.
   script_row_type script [SCRIPT_LEN] = '{
      // bad slot, bad mode, bad mode on attention
      '{'{SLOT_INVALID, 24'h123456, plm_pkg::MODE_SOLID, 16'h0000, 16'h0000}, 1'b1,
        DRIVE_REJECT},
      '{'{SLOT_NOTIFY, 24'hffffff, plm_pkg::MODE_INVALID, 16'h0001, 16'h0001}, 1'b1,
        DRIVE_REJECT},
      '{'{plm_pkg::ATTENTION_SLOT, 24'hffffff, plm_pkg::MODE_INVALID, 16'hffff, 16'h0000},
        1'b1, DRIVE_REJECT},
      // dark request with nothing shown
      '{'{SLOT_BATTERY, 24'h000000, plm_pkg::MODE_SOLID, 16'hffff, 16'hffff}, 1'b1,
        DRIVE_NONE},
      // full-scale battery request is shown
      '{'{SLOT_BATTERY, 24'hffffff, plm_pkg::MODE_TIMED, 16'hffff, 16'hffff}, 1'b1,
        '{1'b1, 24'hffffff, 16'hffff, 16'hffff, STATUS_OK}},
      // solid notification takes over and drops its times
      '{'{SLOT_NOTIFY, 24'h000001, plm_pkg::MODE_SOLID, 16'h1234, 16'h5678}, 1'b1,
        '{1'b1, 24'h000001, 16'h0000, 16'h0000, STATUS_OK}},
      // lower priority update is stored only
      '{'{SLOT_BATTERY, 24'h00ff00, plm_pkg::MODE_HARDWARE, 16'h0100, 16'h0200}, 1'b1,
        DRIVE_NONE},
      // attention solid is forced dark
      '{'{plm_pkg::ATTENTION_SLOT, 24'hff0000, plm_pkg::MODE_SOLID, 16'h0010, 16'h0020},
        1'b0, DRIVE_NONE},
      // attention hardware with no off time turns solid
      '{'{plm_pkg::ATTENTION_SLOT, 24'hff0000, plm_pkg::MODE_HARDWARE, 16'h01f4, 16'h0000},
        1'b0, DRIVE_NONE},
      '{'{plm_pkg::ATTENTION_SLOT, 24'h0000ff, plm_pkg::MODE_HARDWARE, 16'h012c, 16'h02bc},
        1'b0, DRIVE_NONE},
      // darken the chain from the top down to off
      '{'{plm_pkg::ATTENTION_SLOT, 24'h000000, plm_pkg::MODE_TIMED, 16'h0001, 16'h0001},
        1'b0, DRIVE_NONE},
      '{'{SLOT_NOTIFY, 24'h000000, plm_pkg::MODE_TIMED, 16'h0002, 16'h0003}, 1'b0,
        DRIVE_NONE},
      '{'{SLOT_BATTERY, 24'h000000, plm_pkg::MODE_SOLID, 16'h0000, 16'h0000}, 1'b0,
        DRIVE_NONE},
      '{'{SLOT_BATTERY, 24'h000000, plm_pkg::MODE_TIMED, 16'hffff, 16'h0000}, 1'b0,
        DRIVE_NONE},
      '{'{plm_pkg::ATTENTION_SLOT, 24'h000000, plm_pkg::MODE_HARDWARE, 16'h0000, 16'h0000},
        1'b0, DRIVE_NONE},
      '{'{SLOT_NOTIFY, 24'haaaaaa, plm_pkg::MODE_TIMED, 16'h0000, 16'hffff}, 1'b0,
        DRIVE_NONE},
      '{'{plm_pkg::ATTENTION_SLOT, 24'h555555, plm_pkg::MODE_TIMED, 16'hffff, 16'h0000},
        1'b0, DRIVE_NONE},
      '{'{plm_pkg::ATTENTION_SLOT, 24'h000000, plm_pkg::MODE_SOLID, 16'h0000, 16'h0000},
        1'b0, DRIVE_NONE},
      '{'{SLOT_BATTERY, 24'hffffff, plm_pkg::MODE_HARDWARE, 16'hffff, 16'h0000}, 1'b0,
        DRIVE_NONE},
      // darkening the shown notification falls back to the lit battery entry
      '{'{SLOT_NOTIFY, 24'h000000, plm_pkg::MODE_SOLID, 16'h0000, 16'h0000}, 1'b0,
        DRIVE_NONE},
      // attention hardware with zero on time keeps its times
      '{'{plm_pkg::ATTENTION_SLOT, 24'h808080, plm_pkg::MODE_HARDWARE, 16'h0000, 16'h0000},
        1'b0, DRIVE_NONE},
      '{'{SLOT_INVALID, 24'hffffff, plm_pkg::MODE_INVALID, 16'hffff, 16'hffff}, 1'b1,
        DRIVE_REJECT}
   };

   // Predictor state: one entry per slot plus the slot now on the LED.
   logic [COLOR_W-1:0] entry_color [NUM_SLOTS];
   logic [TIME_W-1:0]  entry_on    [NUM_SLOTS];
   logic [TIME_W-1:0]  entry_off   [NUM_SLOTS];
   int                 lit_slot;
   bit                 lit_valid;

   led_drive_type expected_drives [$];

   int idle_pct;
   int stall_pct;
   int mismatches;
   int cycle_count;

   // 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Work out the LED drive caused by one accepted request and advance the state.
   function automatic led_drive_type predict_led_drive(input led_req_type r);
      led_drive_type      d;
      logic [COLOR_W-1:0] col;
      logic [1:0]         md;
      logic [TIME_W-1:0]  t_on;
      logic [TIME_W-1:0]  t_off;
      int                 i;
      bit                 found;
      d = DRIVE_NONE;
      if (int'(r.slot) >= NUM_SLOTS || r.mode == plm_pkg::MODE_INVALID) begin
         return DRIVE_REJECT;
      end
      col   = r.color;
      md    = r.mode;
      t_on  = r.on_ms;
      t_off = r.off_ms;
      if (r.slot == plm_pkg::ATTENTION_SLOT) begin
         if (md == plm_pkg::MODE_SOLID) begin
            col = '0;
         end else if (md == plm_pkg::MODE_HARDWARE && t_on != 0 && t_off == 0) begin
            md = plm_pkg::MODE_SOLID;
         end
      end
      if (md == plm_pkg::MODE_SOLID) begin
         t_on  = '0;
         t_off = '0;
      end
      entry_color[r.slot] = col;
      entry_on[r.slot]    = t_on;
      entry_off[r.slot]   = t_off;
      if (col != 0) begin
         if (!lit_valid || int'(r.slot) >= lit_slot) begin
            lit_slot  = int'(r.slot);
            lit_valid = 1'b1;
            d = '{1'b1, col, t_on, t_off, STATUS_OK};
         end
      end else if (lit_valid && int'(r.slot) == lit_slot) begin
         // Fall back to the highest lit entry below, or switch the LED off.
         d.update = 1'b1;
         found = 1'b0;
         for (i = int'(r.slot) - 1; i >= 0 && !found; i--) begin
            if (entry_color[i] != 0) begin
               lit_slot = i;
               d = '{1'b1, entry_color[i], entry_on[i], entry_off[i], STATUS_OK};
               found = 1'b1;
            end
         end
         if (!found) begin
            lit_valid = 1'b0;
         end
      end
      return d;
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      int p;
      p = $urandom_range(99);
      if (p < 20) return '0;
      if (p < 30) return '1;
      return TIME_W'($urandom);
   endfunction

   // Mostly well-formed requests with a heavy share of dark ones to drive fallbacks.
   function automatic led_req_type random_request();
      led_req_type r;
      int          p;
      p = $urandom_range(99);
      if (p < 5) begin
         r.slot = SLOT_INVALID;
         r.mode = 2'($urandom);
      end else if (p < 10) begin
         r.slot = 2'($urandom_range(NUM_SLOTS - 1));
         r.mode = plm_pkg::MODE_INVALID;
      end else begin
         r.slot = 2'($urandom_range(NUM_SLOTS - 1));
         r.mode = 2'($urandom_range(2));
      end
      p = $urandom_range(99);
      if (p < 30)      r.color = '0;
      else if (p < 40) r.color = plm_pkg::COLOR_MASK;
      else if (p < 50) r.color = COLOR_W'(1) << $urandom_range(COLOR_W - 1);
      else             r.color = COLOR_W'($urandom);
      r.on_ms  = pick_time();
      r.off_ms = pick_time();
      // Hit the attention hardware-to-solid rule often.
      if (r.slot == plm_pkg::ATTENTION_SLOT && r.mode == plm_pkg::MODE_HARDWARE
          && $urandom_range(2) == 0) begin
         r.off_ms = '0;
         if (r.on_ms == 0) r.on_ms = 16'h0001;
      end
      return r;
   endfunction

   // Present one request, hold it until the transfer, then record its drive.
   task automatic send_request(input led_req_type r, input logic typed,
                               input led_drive_type want);
      led_drive_type d;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.slot       <= r.slot;
      req_ch.rgb_color  <= r.color;
      req_ch.flash_mode <= r.mode;
      req_ch.on_ms      <= r.on_ms;
      req_ch.off_ms     <= r.off_ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      d = predict_led_drive(r);
      expected_drives.push_back(typed ? want : d);
   endtask

   task automatic wait_drained();
      while (expected_drives.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input led_drive_type want,
                                  input led_drive_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("%s: expected upd=%0d color=%h on=%h off=%h st=%0d,",
                  what, want.update, want.color, want.on_ms, want.off_ms, want.status);
         $display("   got upd=%0d color=%h on=%h off=%h st=%0d",
                  got.update, got.color, got.on_ms, got.off_ms, got.status);
      end
   endtask

   // Response side: check each transfer, then choose whether to stall next cycle.
   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      led_drive_type got;
      led_drive_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.drive_update, rsp_ch.drive_color, rsp_ch.drive_on_ms,
                 rsp_ch.drive_off_ms, rsp_ch.status};
         if (expected_drives.size() == 0) begin
            report_mismatch("unexpected drive", DRIVE_NONE, got);
         end else begin
            want = expected_drives.pop_front();
            if (got.update != want.update || got.color != want.color
                || got.on_ms != want.on_ms || got.off_ms != want.off_ms
                || got.status != want.status) begin
               report_mismatch("drive mismatch", want, got);
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: end the run if the handshakes stop making progress.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // Main sequence: reset, directed script, then random phases of idling and stalling.
   initial begin
      int row;
      int ph;
      int n;
      mismatches = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      lit_slot   = 0;
      lit_valid  = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         entry_color[s] = '0;
         entry_on[s]    = '0;
         entry_off[s]   = '0;
      end
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.slot       = '0;
      req_ch.rgb_color  = '0;
      req_ch.flash_mode = '0;
      req_ch.on_ms      = '0;
      req_ch.off_ms     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < SCRIPT_LEN; row++) begin
         send_request(script[row].req, script[row].typed, script[row].want);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         // Drop valid and let every pending drive come back before changing pace.
         req_ch.valid <= 1'b0;
         @(posedge clock);
         wait_drained();
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            send_request(random_request(), 1'b0, DRIVE_NONE);
         end
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/plm_pkg.sv
hdl/plm_if.sv
hdl/plm_ctrl.sv
hdl/plm_dp.sv
hdl/priority_led_multiplexer.sv
test/tb.sv
